// File: rtl/core/bmsi_pkg.sv
package bmsi_pkg;

    typedef enum logic [1:0] {
        OP_CPU_WRITE    = 2'd0,
        OP_VIDEO_UPDATE = 2'd1,
        OP_VIDEO_TICK   = 2'd2,
        OP_PRG_LOOKUP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_REVISION_A   = 2'd0,
        CFG_PRG_MASK     = 2'd1,
        CFG_FOUR_SCREEN  = 2'd2,
        CFG_EDGE_RISING  = 2'd3
    } cfg_index_t;

    localparam logic [15:0] WRITE_DECODE_MASK = 16'hE001;
    localparam logic [15:0] REG_BANK_SELECT   = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA     = 16'h8001;
    localparam logic [15:0] REG_MIRROR        = 16'hA000;
    localparam logic [15:0] REG_WRAM_PROTECT  = 16'hA001;
    localparam logic [15:0] REG_IRQ_LATCH     = 16'hC000;
    localparam logic [15:0] REG_IRQ_RELOAD    = 16'hC001;
    localparam logic [15:0] REG_IRQ_DISABLE   = 16'hE000;
    localparam logic [15:0] REG_IRQ_ENABLE    = 16'hE001;

    localparam int          CHR_BANK_COUNT    = 6;
    localparam logic [3:0]  TICK_THRESHOLD    = 4'd8;
    localparam logic [3:0]  TICK_MAX          = 4'd15;

    typedef struct packed {
        op_t         operation;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] mapped_bank;
        logic       irq_line;
        logic       mirror_horizontal;
        logic       wram_enabled;
        logic       wram_writable;
    } result_t;

    typedef struct packed {
        logic       revision_a_mode;
        logic [7:0] prg_bank_mask;
        logic       four_screen;
        logic       edge_rising;
    } cfg_t;

endpackage

// File: rtl/core/bank_mapper_scanline_irq_core.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  operation, bus_address, write_data
// result    out        out_valid/out_stall  mapped_bank, irq_line, mirror_horizontal,
//                                           wram_enabled, wram_writable
// config    in         cfg_we               cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low. The engine works on the input register
// and the result register takes its output when the item fires, so each result passes through
// the input register and then the result register before it is offered on the output.
// rst_n clears all mapper and counter state asynchronously to its power-up values.
// A stalled result holds in the result register; the input register still takes one more
// item, and in_stall rises only when both registers are full.
module bank_mapper_scanline_irq_core
    import bmsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  mapped_bank,
    output logic        irq_line,
    output logic        mirror_horizontal,
    output logic        wram_enabled,
    output logic        wram_writable,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    result_t result;
    result_t out_result;
    logic    fire;
    logic    down_ready;

    assign in_item.operation   = op_t'(operation);
    assign in_item.bus_address = bus_address;
    assign in_item.write_data  = write_data;

    bmsi_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bmsi_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .down_ready (down_ready),
        .fire       (fire),
        .item       (item)
    );

    bmsi_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    bmsi_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .result     (result),
        .down_ready (down_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign mapped_bank       = out_result.mapped_bank;
    assign irq_line          = out_result.irq_line;
    assign mirror_horizontal = out_result.mirror_horizontal;
    assign wram_enabled      = out_result.wram_enabled;
    assign wram_writable     = out_result.wram_writable;

endmodule

// File: rtl/core/bmsi_cfg_regs.sv
module bmsi_cfg_regs
    import bmsi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_REVISION_A:  cfg_next.revision_a_mode = cfg_data[0];
                CFG_PRG_MASK:    cfg_next.prg_bank_mask   = cfg_data;
                CFG_FOUR_SCREEN: cfg_next.four_screen     = cfg_data[0];
                CFG_EDGE_RISING: cfg_next.edge_rising     = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.revision_a_mode <= 1'b0;
            cfg_reg.prg_bank_mask   <= 8'd255;
            cfg_reg.four_screen     <= 1'b0;
            cfg_reg.edge_rising     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/bmsi_in_stage.sv
module bmsi_in_stage
    import bmsi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    input  logic  down_ready,
    output logic  fire,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign fire     = valid_reg && down_ready;
    assign in_stall = valid_reg && !down_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (fire)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
    end

    assign item = item_reg;

endmodule

// File: rtl/core/bmsi_engine.sv
module bmsi_engine
    import bmsi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [2:0] bank_select_reg, bank_select_next;
    logic       chr_invert_reg, chr_invert_next;
    logic       prg_swap_reg, prg_swap_next;
    logic [7:0] chr_banks_reg [CHR_BANK_COUNT];
    logic [7:0] chr_banks_next [CHR_BANK_COUNT];
    logic [7:0] prg_bank0_reg, prg_bank0_next;
    logic [7:0] prg_bank1_reg, prg_bank1_next;
    logic       mirror_reg, mirror_next;
    logic       ram_enable_reg, ram_enable_next;
    logic       ram_write_reg, ram_write_next;
    logic [7:0] reload_value_reg, reload_value_next;
    logic [7:0] counter_reg, counter_next;
    logic       irq_enable_reg, irq_enable_next;
    logic       reload_pending_reg, reload_pending_next;
    logic       irq_pending_reg, irq_pending_next;
    logic       last_a12_reg, last_a12_next;
    logic [3:0] tick_count_reg, tick_count_next;

    logic       a12;
    logic       a12_edge;
    logic [7:0] clocked_counter;
    logic       clocked_irq;
    logic [2:0] chr_slot;
    logic [7:0] chr_bank;
    logic [7:0] prg_bank;
    logic [7:0] second_last;
    logic [7:0] bank;

    // A12 edge detect and counter clocking
    assign a12      = item.bus_address[12];
    assign a12_edge = cfg.edge_rising ? (!last_a12_reg && a12) : (last_a12_reg && !a12);

    always_comb
    begin
        if (counter_reg == 8'd0 || reload_pending_reg)
            clocked_counter = reload_value_reg;
        else
            clocked_counter = counter_reg - 8'd1;
        clocked_irq = (!cfg.revision_a_mode || counter_reg != 8'd0 || reload_pending_reg)
                      && clocked_counter == 8'd0 && irq_enable_reg;
    end

    // character bank lookup
    assign chr_slot = item.bus_address[12:10] ^ {chr_invert_reg, 2'b00};

    always_comb
    begin
        chr_bank = 8'd0;
        if (item.bus_address[15:13] == 3'd0)
        begin
            unique case (chr_slot)
                3'd0, 3'd1: chr_bank = {chr_banks_reg[0][7:1], chr_slot[0]};
                3'd2, 3'd3: chr_bank = {chr_banks_reg[1][7:1], chr_slot[0]};
                3'd4:       chr_bank = chr_banks_reg[2];
                3'd5:       chr_bank = chr_banks_reg[3];
                3'd6:       chr_bank = chr_banks_reg[4];
                default:    chr_bank = chr_banks_reg[5];
            endcase
        end
    end

    // program bank lookup
    assign second_last = cfg.prg_bank_mask - 8'd1;

    always_comb
    begin
        prg_bank = 8'd0;
        if (item.bus_address[15])
        begin
            unique case (item.bus_address[14:13])
                2'd0:    prg_bank = prg_swap_reg ? second_last : prg_bank0_reg;
                2'd1:    prg_bank = prg_bank1_reg;
                2'd2:    prg_bank = prg_swap_reg ? prg_bank0_reg : second_last;
                default: prg_bank = cfg.prg_bank_mask;
            endcase
        end
    end

    always_comb
    begin
        bank_select_next    = bank_select_reg;
        chr_invert_next     = chr_invert_reg;
        prg_swap_next       = prg_swap_reg;
        chr_banks_next      = chr_banks_reg;
        prg_bank0_next      = prg_bank0_reg;
        prg_bank1_next      = prg_bank1_reg;
        mirror_next         = mirror_reg;
        ram_enable_next     = ram_enable_reg;
        ram_write_next      = ram_write_reg;
        reload_value_next   = reload_value_reg;
        counter_next        = counter_reg;
        irq_enable_next     = irq_enable_reg;
        reload_pending_next = reload_pending_reg;
        irq_pending_next    = irq_pending_reg;
        last_a12_next       = last_a12_reg;
        tick_count_next     = tick_count_reg;
        bank                = 8'd0;

        if (fire)
        begin
            unique case (item.operation)
                OP_CPU_WRITE:
                begin
                    unique case (item.bus_address & WRITE_DECODE_MASK)
                        REG_BANK_SELECT:
                        begin
                            bank_select_next = item.write_data[2:0];
                            chr_invert_next  = item.write_data[7];
                            prg_swap_next    = item.write_data[6];
                        end
                        REG_BANK_DATA:
                        begin
                            for (int i = 0; i < CHR_BANK_COUNT; i++)
                            begin
                                if (bank_select_reg == 3'(i))
                                    chr_banks_next[i] = item.write_data;
                            end
                            if (bank_select_reg == 3'd6)
                                prg_bank0_next = item.write_data & cfg.prg_bank_mask;
                            if (bank_select_reg == 3'd7)
                                prg_bank1_next = item.write_data & cfg.prg_bank_mask;
                        end
                        REG_MIRROR:
                        begin
                            if (!cfg.four_screen)
                                mirror_next = item.write_data[0];
                        end
                        REG_WRAM_PROTECT:
                        begin
                            ram_enable_next = item.write_data[7];
                            ram_write_next  = !item.write_data[6];
                        end
                        REG_IRQ_LATCH:
                            reload_value_next = item.write_data;
                        REG_IRQ_RELOAD:
                        begin
                            if (cfg.revision_a_mode)
                                reload_pending_next = 1'b1;
                            counter_next = 8'd0;
                        end
                        REG_IRQ_DISABLE:
                        begin
                            irq_enable_next  = 1'b0;
                            irq_pending_next = 1'b0;
                        end
                        REG_IRQ_ENABLE:
                            irq_enable_next = 1'b1;
                        default:
                        begin
                        end
                    endcase
                end
                OP_VIDEO_UPDATE:
                begin
                    last_a12_next = a12;
                    if (a12_edge)
                    begin
                        if (tick_count_reg > TICK_THRESHOLD)
                        begin
                            counter_next        = clocked_counter;
                            reload_pending_next = 1'b0;
                            if (clocked_irq)
                                irq_pending_next = 1'b1;
                        end
                        tick_count_next = 4'd0;
                    end
                    bank = chr_bank;
                end
                OP_VIDEO_TICK:
                begin
                    if (tick_count_reg < TICK_MAX)
                        tick_count_next = tick_count_reg + 4'd1;
                end
                default:
                    bank = prg_bank;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg    <= 3'd0;
            chr_invert_reg     <= 1'b0;
            prg_swap_reg       <= 1'b0;
            for (int i = 0; i < CHR_BANK_COUNT; i++)
            begin
                chr_banks_reg[i] <= 8'd0;
            end
            prg_bank0_reg      <= 8'd0;
            prg_bank1_reg      <= 8'd1;
            mirror_reg         <= 1'b0;
            ram_enable_reg     <= 1'b1;
            ram_write_reg      <= 1'b1;
            reload_value_reg   <= 8'd255;
            counter_reg        <= 8'd0;
            irq_enable_reg     <= 1'b0;
            reload_pending_reg <= 1'b0;
            irq_pending_reg    <= 1'b0;
            last_a12_reg       <= 1'b0;
            tick_count_reg     <= 4'd0;
        end
        else
        begin
            bank_select_reg    <= bank_select_next;
            chr_invert_reg     <= chr_invert_next;
            prg_swap_reg       <= prg_swap_next;
            chr_banks_reg      <= chr_banks_next;
            prg_bank0_reg      <= prg_bank0_next;
            prg_bank1_reg      <= prg_bank1_next;
            mirror_reg         <= mirror_next;
            ram_enable_reg     <= ram_enable_next;
            ram_write_reg      <= ram_write_next;
            reload_value_reg   <= reload_value_next;
            counter_reg        <= counter_next;
            irq_enable_reg     <= irq_enable_next;
            reload_pending_reg <= reload_pending_next;
            irq_pending_reg    <= irq_pending_next;
            last_a12_reg       <= last_a12_next;
            tick_count_reg     <= tick_count_next;
        end
    end

    assign result.mapped_bank       = bank;
    assign result.irq_line          = irq_pending_next;
    assign result.mirror_horizontal = mirror_next;
    assign result.wram_enabled      = ram_enable_next;
    assign result.wram_writable     = ram_write_next;

endmodule

// File: rtl/core/bmsi_out_stage.sv
module bmsi_out_stage
    import bmsi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  result_t result,
    output logic    down_ready,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign down_ready = !valid_reg || !out_stall;

    always_comb
    begin
        if (fire)
            valid_next = 1'b1;
        else if (valid_reg && out_stall)
            valid_next = 1'b1;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
